// ===== rtl/ccud_pkg.sv =====
// Shared types, request codes and calendar helpers for the clock/calendar counter.
// No dependencies.
`default_nettype none

package ccud_pkg;

  typedef enum logic [1:0] {
    REQ_UP   = 2'd0,
    REQ_DOWN = 2'd1,
    REQ_LOAD = 2'd2
  } req_t;

  // sec in the lowest bits, year in the highest: matches the stream packing
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] min;
    logic [5:0] sec;
  } ccud_time_t;

  localparam int TIME_W = $bits(ccud_time_t);

  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [4:0] DAY_MIN   = 5'd1;
  localparam logic [3:0] MONTH_MIN = 4'd1;
  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [6:0] YEAR_MAX  = 7'd99;

  localparam ccud_time_t TIME_RESET = '{year: 7'd0, month: MONTH_MIN, day: DAY_MIN,
                                        hour: 5'd0, min: 6'd0, sec: 6'd0};

  // Years 2000..2099: only 2000 is a century year and it is divisible by 400,
  // so the leap rule reduces to the offset being a multiple of four.
  function automatic logic leap_year(input logic [6:0] year);
    leap_year = (year[1:0] == 2'b00);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month,
                                            input logic [6:0] year);
    case (month) inside
      4'd2:                      month_days = leap_year(year) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_days = 5'd30;
      default:                   month_days = 5'd31;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ccud_in_reg.sv =====
// Input holding register for the request stream.
// Depends on ccud_pkg.
`default_nettype none

module ccud_in_reg (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  ccud_pkg::req_t       req,
  input  ccud_pkg::ccud_time_t load,
  input  wire                  advance,   // downstream takes the held item
  output logic                 in_valid,
  output ccud_pkg::req_t       in_req,
  output ccud_pkg::ccud_time_t in_load
);
  import ccud_pkg::*;

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req  <= req;
      in_load <= load;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ccud_next.sv =====
// Next-state logic of the time/date counter: tick up, tick down, load.
// Depends on ccud_pkg.
`default_nettype none

module ccud_next (
  input  ccud_pkg::ccud_time_t cur,
  input  ccud_pkg::req_t       req,
  input  ccud_pkg::ccud_time_t load,
  output ccud_pkg::ccud_time_t nxt,
  output logic                 rolled
);
  import ccud_pkg::*;

  ccud_time_t up_t, dn_t, ld_t;
  logic       up_roll, dn_roll;
  logic [3:0] dn_month;
  logic [6:0] dn_year;

  // count up
  always_comb begin
    up_t    = cur;
    up_roll = 1'b0;
    if (cur.sec < SEC_MAX) begin
      up_t.sec = cur.sec + 6'd1;
    end else begin
      up_t.sec = 6'd0;
      if (cur.min < MIN_MAX) begin
        up_t.min = cur.min + 6'd1;
      end else begin
        up_t.min = 6'd0;
        if (cur.hour < HOUR_MAX) begin
          up_t.hour = cur.hour + 5'd1;
        end else begin
          up_t.hour = 5'd0;
          up_roll   = 1'b1;
        end
      end
    end
    if (up_roll) begin
      if (cur.day < month_days(cur.month, cur.year)) begin
        up_t.day = cur.day + 5'd1;
      end else begin
        up_t.day = DAY_MIN;
        if (cur.month >= MONTH_MAX) begin
          up_t.month = MONTH_MIN;
          up_t.year  = (cur.year >= YEAR_MAX) ? 7'd0 : cur.year + 7'd1;
        end else begin
          up_t.month = cur.month + 4'd1;
        end
      end
    end
  end

  // count down; entering a month takes its length under the entered year
  always_comb begin
    dn_t    = cur;
    dn_roll = 1'b0;
    if (cur.month <= MONTH_MIN) begin
      dn_month = MONTH_MAX;
      dn_year  = (cur.year == 7'd0) ? YEAR_MAX : cur.year - 7'd1;
    end else begin
      dn_month = cur.month - 4'd1;
      dn_year  = cur.year;
    end
    if (cur.sec > 6'd0) begin
      dn_t.sec = cur.sec - 6'd1;
    end else begin
      dn_t.sec = SEC_MAX;
      if (cur.min > 6'd0) begin
        dn_t.min = cur.min - 6'd1;
      end else begin
        dn_t.min = MIN_MAX;
        if (cur.hour > 5'd0) begin
          dn_t.hour = cur.hour - 5'd1;
        end else begin
          dn_t.hour = HOUR_MAX;
          dn_roll   = 1'b1;
        end
      end
    end
    if (dn_roll) begin
      if (cur.day > DAY_MIN) begin
        dn_t.day = cur.day - 5'd1;
      end else begin
        dn_t.month = dn_month;
        dn_t.year  = dn_year;
        dn_t.day   = month_days(dn_month, dn_year);
      end
    end
  end

  // load with saturation into each field's range (day: lower bound only)
  always_comb begin
    ld_t.sec   = (load.sec > SEC_MAX) ? SEC_MAX : load.sec;
    ld_t.min   = (load.min > MIN_MAX) ? MIN_MAX : load.min;
    ld_t.hour  = (load.hour > HOUR_MAX) ? HOUR_MAX : load.hour;
    ld_t.day   = (load.day < DAY_MIN) ? DAY_MIN : load.day;
    ld_t.month = (load.month < MONTH_MIN) ? MONTH_MIN :
                 (load.month > MONTH_MAX) ? MONTH_MAX : load.month;
    ld_t.year  = (load.year > YEAR_MAX) ? YEAR_MAX : load.year;
  end

  always_comb begin
    case (req)
      REQ_UP: begin
        nxt    = up_t;
        rolled = up_roll;
      end
      REQ_DOWN: begin
        nxt    = dn_t;
        rolled = dn_roll;
      end
      REQ_LOAD: begin
        nxt    = ld_t;
        rolled = 1'b0;
      end
      default: begin
        nxt    = cur;
        rolled = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/clock_calendar_up_down.sv =====
// Time and date counter with up, down and load requests.
// Path: an accepted request waits in the input register; its result is then registered onto m_*.
// Throughput: one item per cycle while the result is not stalled; the input register and the
// result register both advance whenever the result register is empty or being taken.
// Reset (rst, synchronous): 00:00:00, day 1, month 1, year offset 0; both stages empty.
// Depends on ccud_pkg, ccud_in_reg, ccud_next.
`default_nettype none

module clock_calendar_up_down (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // load_sec, load_min, load_hour, load_day, load_month,
                                 // load_year, zero pad (bits 39:33)
  input  wire  [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // sec_now, min_now, hour_now, day_now, month_now,
                                 // year_now, zero pad (bits 39:33)
  output logic [0:0]  m_tuser    // day_rolled
);
  import ccud_pkg::*;

  logic       advance;    // result register free or being emptied this cycle
  logic       in_valid;
  req_t       in_req;
  ccud_time_t in_load;
  ccud_time_t cur;        // the counter itself
  ccud_time_t nxt;
  logic       rolled;
  ccud_time_t out_time;

  assign advance = !m_tvalid || m_tready;

  ccud_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req      (req_t'(s_tuser)),
    .load     (ccud_time_t'(s_tdata[TIME_W-1:0])),
    .advance  (advance),
    .in_valid (in_valid),
    .in_req   (in_req),
    .in_load  (in_load)
  );

  ccud_next u_next (
    .cur    (cur),
    .req    (in_req),
    .load   (in_load),
    .nxt    (nxt),
    .rolled (rolled)
  );

  // calendar state moves once per item, as it leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= TIME_RESET;
    end else if (in_valid && advance) begin
      cur <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_time   <= nxt;
      m_tuser[0] <= rolled;
    end
  end

  assign m_tdata = {{(40-TIME_W){1'b0}}, out_time};

  // day_rolled is only set across midnight
  a_roll_midnight: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      (out_time.sec == 6'd0 && out_time.min == 6'd0 && out_time.hour == 5'd0) ||
      (out_time.sec == SEC_MAX && out_time.min == MIN_MAX && out_time.hour == HOUR_MAX))
    else $error("day_rolled without a midnight crossing");

  // counter fields stay in range
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    cur.sec <= SEC_MAX && cur.min <= MIN_MAX && cur.hour <= HOUR_MAX &&
    cur.day >= DAY_MIN && cur.month >= MONTH_MIN && cur.month <= MONTH_MAX &&
    cur.year <= YEAR_MAX)
    else $error("calendar state out of range");

  // a held item with a stalled result blocks new input
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |-> !s_tready)
    else $error("input taken while the held item cannot move");

  // state untouched while no item moves through
  a_cur_hold: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && advance) |=> $stable(cur))
    else $error("calendar changed without an item");

  a_reset_val: assert property (@(posedge clk)
    rst |=> cur == TIME_RESET && !m_tvalid)
    else $error("reset values wrong");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the clock/calendar counter: streams up, down and load
// requests, predicts every time/date result and compares it field by field.
// Depends on ccud_pkg and clock_calendar_up_down.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ccud_pkg::*;

  // Request code the block leaves unused: state holds, current time comes back.
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam int N_ITEMS      = 1350;
  localparam int CALM_ITEMS   = 150;   // tail of the run with no idling on either side
  localparam int DRAIN_AT     = 600;   // sender waits for an empty pipe before this item
  localparam int LONG_HOLD_AT = 300;   // result count that starts the long receiver hold
  localparam int LONG_HOLD    = 120;
  localparam int TAIL_CYCLES  = 10;

  typedef struct packed {
    logic [1:0] req;
    ccud_time_t load;
    logic       drain_first;
  } cal_item_t;

  typedef struct packed {
    ccud_time_t now;
    logic       rolled;
  } cal_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;

  cal_item_t   pend_items[$];    // items still to be offered
  cal_result_t exp_results[$];   // predicted results, oldest first
  ccud_time_t  cal_state = TIME_RESET;
  cal_item_t   nxt_item;
  int          send_gap = 0;
  int          recv_stall = 0;
  int          results_seen = 0;
  bit          long_hold_done = 1'b0;
  bit          calm = 1'b0;
  int          err_count = 0;

  clock_calendar_up_down i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),    // load_sec, load_min, load_hour, load_day, load_month,
                           // load_year, zero pad (bits 39:33)
    .s_tuser (s_tuser),    // req_type
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),    // sec_now, min_now, hour_now, day_now, month_now,
                           // year_now, zero pad (bits 39:33)
    .m_tuser (m_tuser)     // day_rolled
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Leap rule over the full Gregorian definition, year given as offset from 2000.
  function automatic logic is_leap_year(input logic [6:0] off);
    int y;
    y = int'(off) + 2000;
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic [6:0] off);
    case (month)
      4'd2:                    return is_leap_year(off) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                 return 5'd31;
    endcase
  endfunction

  // Applies one accepted request to the shadow calendar and queues the result.
  function automatic void predict_calendar(input logic [1:0] req, input ccud_time_t ld);
    ccud_time_t  t;
    cal_result_t r;
    logic        rolled;
    t = cal_state;
    rolled = 1'b0;
    case (req)
      REQ_UP: begin
        if (t.sec < SEC_MAX) t.sec = t.sec + 6'd1;
        else begin
          t.sec = 6'd0;
          if (t.min < MIN_MAX) t.min = t.min + 6'd1;
          else begin
            t.min = 6'd0;
            if (t.hour < HOUR_MAX) t.hour = t.hour + 5'd1;
            else begin
              t.hour = 5'd0;
              rolled = 1'b1;
            end
          end
        end
        if (rolled) begin
          // a loaded day past the month end also rolls into the next month
          if (t.day < days_in_month(t.month, t.year)) t.day = t.day + 5'd1;
          else begin
            t.day = DAY_MIN;
            if (t.month >= MONTH_MAX) begin
              t.month = MONTH_MIN;
              t.year = (t.year >= YEAR_MAX) ? 7'd0 : t.year + 7'd1;
            end else begin
              t.month = t.month + 4'd1;
            end
          end
        end
      end
      REQ_DOWN: begin
        if (t.sec > 6'd0) t.sec = t.sec - 6'd1;
        else begin
          t.sec = SEC_MAX;
          if (t.min > 6'd0) t.min = t.min - 6'd1;
          else begin
            t.min = MIN_MAX;
            if (t.hour > 5'd0) t.hour = t.hour - 5'd1;
            else begin
              t.hour = HOUR_MAX;
              rolled = 1'b1;
            end
          end
        end
        if (rolled) begin
          if (t.day > DAY_MIN) t.day = t.day - 5'd1;
          else begin
            if (t.month <= MONTH_MIN) begin
              t.month = MONTH_MAX;
              t.year = (t.year == 7'd0) ? YEAR_MAX : t.year - 7'd1;
            end else begin
              t.month = t.month - 4'd1;
            end
            // length of the month entered, leap rule on the year entered
            t.day = days_in_month(t.month, t.year);
          end
        end
      end
      REQ_LOAD: begin
        t.sec   = (ld.sec > SEC_MAX) ? SEC_MAX : ld.sec;
        t.min   = (ld.min > MIN_MAX) ? MIN_MAX : ld.min;
        t.hour  = (ld.hour > HOUR_MAX) ? HOUR_MAX : ld.hour;
        t.day   = (ld.day == 5'd0) ? DAY_MIN : ld.day;
        t.month = (ld.month < MONTH_MIN) ? MONTH_MIN :
                  (ld.month > MONTH_MAX) ? MONTH_MAX : ld.month;
        t.year  = (ld.year > YEAR_MAX) ? YEAR_MAX : ld.year;
      end
      default: ;  // unused code: hold
    endcase
    cal_state = t;
    r.now = t;
    r.rolled = rolled;
    exp_results.push_back(r);
  endfunction

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      err_count++;
      $display("tb_top: mismatch %s at result %0d: got %0d, want %0d",
               name, results_seen, got, want);
    end
  endtask

  function automatic void queue_item(input logic [1:0] req, input ccud_time_t ld);
    cal_item_t it;
    it.req = req;
    it.load = ld;
    it.drain_first = (pend_items.size() == DRAIN_AT);
    pend_items.push_back(it);
  endfunction

  function automatic ccud_time_t at_time(input int h, input int m, input int s,
                                         input int d, input int mo, input int y);
    ccud_time_t t;
    t.hour = 5'(h);
    t.min = 6'(m);
    t.sec = 6'(s);
    t.day = 5'(d);
    t.month = 4'(mo);
    t.year = 7'(y);
    return t;
  endfunction

  function automatic ccud_time_t rand_fields();
    logic [63:0] rbits;
    rbits = {$urandom(), $urandom()};
    return rbits[TIME_W-1:0];
  endfunction

  // Driver: offers the next pending item and predicts every accepted one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      cal_state = TIME_RESET;
      send_gap = 0;
    end else begin
      calm <= (pend_items.size() < CALM_ITEMS);
      if (!s_tvalid || s_tready) begin
        if (s_tvalid) predict_calendar(s_tuser, s_tdata[TIME_W-1:0]);
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pend_items.size() == 0 ||
                     (pend_items[0].drain_first && exp_results.size() != 0)) begin
          // nothing left, or holding back until the pipe has emptied
          s_tvalid <= 1'b0;
        end else begin
          nxt_item = pend_items.pop_front();
          s_tuser  <= nxt_item.req;
          s_tdata  <= {{(40-TIME_W){1'b0}}, nxt_item.load};
          s_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 17);
        end
      end
    end
  end

  // Monitor: takes results, checks them against the oldest prediction, and
  // throttles m_tready with random bursts plus one long hold.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (exp_results.size() == 0) begin
          check_field("result with none expected", 1, 0);
        end else begin
          cal_result_t want;
          ccud_time_t  got;
          want = exp_results.pop_front();
          got = m_tdata[TIME_W-1:0];
          check_field("sec_now", 32'(got.sec), 32'(want.now.sec));
          check_field("min_now", 32'(got.min), 32'(want.now.min));
          check_field("hour_now", 32'(got.hour), 32'(want.now.hour));
          check_field("day_now", 32'(got.day), 32'(want.now.day));
          check_field("month_now", 32'(got.month), 32'(want.now.month));
          check_field("year_now", 32'(got.year), 32'(want.now.year));
          check_field("day_rolled", 32'(m_tuser[0]), 32'(want.rolled));
          check_field("tdata pad", 32'(m_tdata[39:TIME_W]), 0);
        end
      end
      if (results_seen == LONG_HOLD_AT && !long_hold_done) begin
        // long back-pressure: sender keeps offering, block fills and stalls
        recv_stall = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 17);
      end
    end
  end

  initial begin
    ccud_time_t  ld;
    logic [4:0]  mdays;
    logic [1:0]  tick_req;
    int          run;
    int          mode;
    bit          go_up;

    // Directed part: rollovers at both ends, leap Februaries, saturation,
    // days past the month end and the unused request code.
    queue_item(REQ_UP, '0);                              // from reset
    queue_item(REQ_DOWN, '0);
    queue_item(REQ_DOWN, '0);                            // day one, month 1, year 0: wraps to 99
    queue_item(REQ_UP, '0);                              // and back up across new year
    queue_item(REQ_LOAD, at_time(23, 59, 59, 28, 2, 1));
    queue_item(REQ_UP, '0);                              // non-leap Feb 28 -> Mar 1
    queue_item(REQ_LOAD, at_time(23, 59, 59, 28, 2, 4));
    queue_item(REQ_UP, '0);                              // leap Feb 28 -> Feb 29
    queue_item(REQ_LOAD, at_time(0, 0, 0, 1, 3, 4));
    queue_item(REQ_DOWN, '0);                            // back into leap February
    queue_item(REQ_LOAD, at_time(0, 0, 0, 1, 3, 0));
    queue_item(REQ_DOWN, '0);                            // 2000 is leap by the 400 rule
    queue_item(REQ_LOAD, at_time(0, 0, 0, 1, 3, 1));
    queue_item(REQ_DOWN, '0);
    queue_item(REQ_LOAD, at_time(31, 63, 63, 31, 15, 127));  // all fields but the day saturate
    queue_item(REQ_UP, '0);                              // year 99 wraps to 0
    queue_item(REQ_LOAD, at_time(0, 0, 0, 0, 0, 0));     // day and month 0 go to 1
    queue_item(REQ_DOWN, '0);
    queue_item(REQ_LOAD, at_time(23, 59, 59, 31, 2, 1)); // day past month end
    queue_item(REQ_UP, '0);
    queue_item(REQ_LOAD, at_time(0, 0, 0, 31, 2, 4));
    queue_item(REQ_DOWN, '0);                            // steps down from the odd day
    queue_item(REQ_LOAD, at_time(23, 59, 59, 30, 4, 10));
    queue_item(REQ_UP, '0);
    queue_item(REQ_NONE, rand_fields());

    // Random part: mostly a load near a day boundary followed by a run of ticks,
    // the rest fully random noise over every request code.
    while (pend_items.size() < N_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_item(2'($urandom_range(0, 3)), rand_fields());
      end else begin
        go_up = 1'($urandom_range(0, 1));
        ld.month = ($urandom_range(0, 3) == 0) ? (go_up ? MONTH_MAX : MONTH_MIN)
                                               : 4'($urandom_range(1, 12));
        case ($urandom_range(0, 3))
          0:       ld.year = 7'd0;
          1:       ld.year = YEAR_MAX;
          2:       ld.year = 7'($urandom_range(0, 99));
          default: ld.year = 7'($urandom_range(0, 127));
        endcase
        if (go_up) begin
          mdays = days_in_month(ld.month, ld.year);
          ld.sec  = 6'($urandom_range(48, 63));
          ld.min  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : MIN_MAX;
          ld.hour = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : HOUR_MAX;
          ld.day  = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                : mdays - 5'($urandom_range(0, 1));
        end else begin
          ld.sec  = 6'($urandom_range(0, 9));
          ld.min  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'd0;
          ld.hour = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'd0;
          ld.day  = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(1, 2));
        end
        queue_item(REQ_LOAD, ld);
        run = $urandom_range(1, 14);
        mode = $urandom_range(0, 3);
        repeat (run) begin
          if (mode == 3) tick_req = ($urandom_range(0, 1) == 0) ? REQ_UP : REQ_DOWN;
          else tick_req = go_up ? REQ_UP : REQ_DOWN;
          queue_item(tick_req, rand_fields());
        end
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Sampled on the falling edge so the handshake signals have settled.
    while (pend_items.size() != 0 || s_tvalid || exp_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    check_field("expectations left over", exp_results.size(), 0);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
